### rtl/core/stt_pkg.sv
// stt_pkg: shared types, character codes and token kind codes for the
// source text tokenizer. No dependencies; used by every file in rtl/core.
`timescale 1ns / 1ps

package stt_pkg;

    // lexeme length limit
    localparam int LENGTH_BITS = 16;
    localparam int LEN_EFF_BITS = (LENGTH_BITS > 16) ? 16 : LENGTH_BITS;
    localparam int LEN_MAX_INT = (1 << LEN_EFF_BITS) - 1;
    localparam logic [15:0] LEN_MAX = 16'(LEN_MAX_INT);

    // largest number value
    localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

    // result queue depth
    localparam int QDEPTH = 4;
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_RBRC  = 8'h7D;

    // token kinds
    localparam logic [4:0] K_EOB     = 5'd0;
    localparam logic [4:0] K_NEWLINE = 5'd1;
    localparam logic [4:0] K_PLUS    = 5'd2;
    localparam logic [4:0] K_MINUS   = 5'd3;
    localparam logic [4:0] K_STAR    = 5'd4;
    localparam logic [4:0] K_SLASH   = 5'd5;
    localparam logic [4:0] K_LT      = 5'd6;
    localparam logic [4:0] K_LE      = 5'd7;
    localparam logic [4:0] K_GT      = 5'd8;
    localparam logic [4:0] K_GE      = 5'd9;
    localparam logic [4:0] K_ASSIGN  = 5'd10;
    localparam logic [4:0] K_EQEQ    = 5'd11;
    localparam logic [4:0] K_BANG    = 5'd12;
    localparam logic [4:0] K_NE      = 5'd13;
    localparam logic [4:0] K_COMMA   = 5'd14;
    localparam logic [4:0] K_LBRACE  = 5'd15;
    localparam logic [4:0] K_RBRACE  = 5'd16;
    localparam logic [4:0] K_LPAREN  = 5'd17;
    localparam logic [4:0] K_RPAREN  = 5'd18;
    localparam logic [4:0] K_RANGE   = 5'd19;
    localparam logic [4:0] K_IDENT   = 5'd20;
    localparam logic [4:0] K_NUMBER  = 5'd21;
    localparam logic [4:0] K_LITERAL = 5'd22;
    localparam logic [4:0] K_INVALID = 5'd23;
    localparam logic [4:0] K_UNTERM  = 5'd24;

    // scanner phase, one-hot
    typedef enum logic [9:0] {
        PH_IDLE   = 10'b00_0000_0001,
        PH_DOT    = 10'b00_0000_0010,
        PH_LT     = 10'b00_0000_0100,
        PH_GT     = 10'b00_0000_1000,
        PH_EQ     = 10'b00_0001_0000,
        PH_BANG   = 10'b00_0010_0000,
        PH_IDENT  = 10'b00_0100_0000,
        PH_NUMBER = 10'b00_1000_0000,
        PH_LIT_SQ = 10'b01_0000_0000,
        PH_LIT_DQ = 10'b10_0000_0000
    } phase_t;

    // one result token
    typedef struct packed {
        logic [4:0]  token_kind;
        logic [30:0] number_value;
        logic [31:0] start_offset;
        logic [15:0] token_length;
        logic [31:0] line_number;
        logic        saturated;
        logic        last_of_run;
    } tok_t;

    // up to two tokens from one scanned byte, first one always in t0
    typedef struct packed {
        logic v0;
        logic v1;
        tok_t t0;
        tok_t t1;
    } push_t;

    function automatic tok_t make_tok(logic [4:0] kind, logic [30:0] value,
                                      logic [31:0] start, logic [15:0] len,
                                      logic [31:0] line, logic sat);
        tok_t t;
        t.token_kind   = kind;
        t.number_value = value;
        t.start_offset = start;
        t.token_length = len;
        t.line_number  = line;
        t.saturated    = sat;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

endpackage

### rtl/core/stt_scanner.sv
// stt_scanner: scanner state registers and the per-byte next-state logic.
// Produces up to two tokens per scanned byte. Depends on stt_pkg.
`timescale 1ns / 1ps

module stt_scanner (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              scan_fire,
    input  logic [7:0]        text_byte,
    input  logic              end_of_input,
    output stt_pkg::push_t    push
);

    stt_pkg::phase_t phase_reg, phase_next;
    logic [30:0] acc_reg, acc_next;
    logic [31:0] start_reg, start_next;
    logic [15:0] count_reg, count_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] line_reg, line_next;
    logic        clip_reg, clip_next;

    // byte classes
    logic       is_alpha, is_dig;
    logic [3:0] dig_val;

    assign is_alpha = (text_byte inside {[stt_pkg::CH_LC_A:stt_pkg::CH_LC_Z],
                                         [stt_pkg::CH_UC_A:stt_pkg::CH_UC_Z],
                                         stt_pkg::CH_UNDER});
    assign is_dig   = (text_byte inside {[stt_pkg::CH_0:stt_pkg::CH_9]});
    assign dig_val  = 4'(text_byte - stt_pkg::CH_0);

    // token held by the current phase
    logic          flush_v;
    stt_pkg::tok_t flush_t;

    always_comb begin
        flush_v = (phase_reg != stt_pkg::PH_IDLE);
        flush_t = stt_pkg::make_tok(stt_pkg::K_INVALID, '0, start_reg, 16'd1,
                                    line_reg, 1'b0);
        case (phase_reg)
            stt_pkg::PH_DOT:  flush_t.token_kind = stt_pkg::K_INVALID;
            stt_pkg::PH_LT:   flush_t.token_kind = stt_pkg::K_LT;
            stt_pkg::PH_GT:   flush_t.token_kind = stt_pkg::K_GT;
            stt_pkg::PH_EQ:   flush_t.token_kind = stt_pkg::K_ASSIGN;
            stt_pkg::PH_BANG: flush_t.token_kind = stt_pkg::K_BANG;
            stt_pkg::PH_IDENT: begin
                flush_t = stt_pkg::make_tok(stt_pkg::K_IDENT, '0, start_reg,
                                            count_reg, line_reg, clip_reg);
            end
            stt_pkg::PH_NUMBER: begin
                flush_t = stt_pkg::make_tok(stt_pkg::K_NUMBER, acc_reg, start_reg,
                                            count_reg, line_reg, clip_reg);
            end
            stt_pkg::PH_LIT_SQ, stt_pkg::PH_LIT_DQ: begin
                flush_t = stt_pkg::make_tok(stt_pkg::K_UNTERM, '0, start_reg,
                                            count_reg, line_reg, clip_reg);
            end
            default: flush_t.token_kind = stt_pkg::K_INVALID;
        endcase
    end

    // scan of the byte from the idle phase
    logic            fr_emit, fr_begin, fr_nl, fr_restart;
    stt_pkg::tok_t   fr_tok;
    stt_pkg::phase_t fr_phase;
    logic [31:0]     fr_start;
    logic [15:0]     fr_count;
    logic [30:0]     fr_acc;

    always_comb begin
        fr_emit    = 1'b1;
        fr_begin   = 1'b0;
        fr_nl      = 1'b0;
        fr_restart = 1'b0;
        fr_phase   = stt_pkg::PH_IDLE;
        fr_start   = offset_reg;
        fr_count   = 16'd1;
        fr_acc     = '0;
        fr_tok     = stt_pkg::make_tok(stt_pkg::K_INVALID, '0, offset_reg, 16'd1,
                                       line_reg, 1'b0);
        case (text_byte)
            stt_pkg::CH_SPACE, stt_pkg::CH_TAB, stt_pkg::CH_CR: fr_emit = 1'b0;
            stt_pkg::CH_LF: begin
                fr_tok.token_kind = stt_pkg::K_NEWLINE;
                fr_nl = 1'b1;
            end
            stt_pkg::CH_PLUS:  fr_tok.token_kind = stt_pkg::K_PLUS;
            stt_pkg::CH_MINUS: fr_tok.token_kind = stt_pkg::K_MINUS;
            stt_pkg::CH_STAR:  fr_tok.token_kind = stt_pkg::K_STAR;
            stt_pkg::CH_SLASH: fr_tok.token_kind = stt_pkg::K_SLASH;
            stt_pkg::CH_COMMA: fr_tok.token_kind = stt_pkg::K_COMMA;
            stt_pkg::CH_LBRC:  fr_tok.token_kind = stt_pkg::K_LBRACE;
            stt_pkg::CH_RBRC:  fr_tok.token_kind = stt_pkg::K_RBRACE;
            stt_pkg::CH_LPAR:  fr_tok.token_kind = stt_pkg::K_LPAREN;
            stt_pkg::CH_RPAR:  fr_tok.token_kind = stt_pkg::K_RPAREN;
            stt_pkg::CH_DOT: begin
                fr_emit = 1'b0; fr_begin = 1'b1; fr_phase = stt_pkg::PH_DOT;
            end
            stt_pkg::CH_LT: begin
                fr_emit = 1'b0; fr_begin = 1'b1; fr_phase = stt_pkg::PH_LT;
            end
            stt_pkg::CH_GT: begin
                fr_emit = 1'b0; fr_begin = 1'b1; fr_phase = stt_pkg::PH_GT;
            end
            stt_pkg::CH_EQ: begin
                fr_emit = 1'b0; fr_begin = 1'b1; fr_phase = stt_pkg::PH_EQ;
            end
            stt_pkg::CH_BANG: begin
                fr_emit = 1'b0; fr_begin = 1'b1; fr_phase = stt_pkg::PH_BANG;
            end
            stt_pkg::CH_SQ, stt_pkg::CH_DQ: begin
                fr_emit  = 1'b0;
                fr_begin = 1'b1;
                fr_phase = (text_byte == stt_pkg::CH_DQ) ? stt_pkg::PH_LIT_DQ
                                                         : stt_pkg::PH_LIT_SQ;
                fr_start = offset_reg + 32'd1;
                fr_count = 16'd0;
            end
            stt_pkg::CH_NUL: begin
                fr_tok.token_kind   = stt_pkg::K_EOB;
                fr_tok.token_length = 16'd0;
                fr_restart = 1'b1;
            end
            default: begin
                if (is_alpha) begin
                    fr_emit = 1'b0; fr_begin = 1'b1; fr_phase = stt_pkg::PH_IDENT;
                end else if (is_dig) begin
                    fr_emit  = 1'b0;
                    fr_begin = 1'b1;
                    fr_phase = stt_pkg::PH_NUMBER;
                    fr_acc   = 31'(dig_val);
                end
            end
        endcase
    end

    // length growth and decimal accumulation
    logic [15:0] grow_count;
    logic        grow_clip;
    logic [34:0] acc_x10;
    logic        acc_ovf;

    assign grow_count = (count_reg < stt_pkg::LEN_MAX) ? count_reg + 16'd1 : count_reg;
    assign grow_clip  = clip_reg | (count_reg >= stt_pkg::LEN_MAX);
    assign acc_x10    = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                        + 35'(dig_val);
    assign acc_ovf    = (acc_x10[34:31] != 4'd0);

    // next state and token selection
    logic          a_v, b_v, chain, restart;
    stt_pkg::tok_t a_t, b_t;
    logic [7:0]    second_ch, quote_ch;

    always_comb begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        start_next  = start_reg;
        count_next  = count_reg;
        clip_next   = clip_reg;
        line_next   = line_reg;
        offset_next = offset_reg + 32'd1;
        a_v     = 1'b0;
        b_v     = 1'b0;
        a_t     = flush_t;
        b_t     = fr_tok;
        chain   = 1'b0;
        restart = 1'b0;
        second_ch = (phase_reg == stt_pkg::PH_DOT) ? stt_pkg::CH_DOT : stt_pkg::CH_EQ;
        quote_ch  = (phase_reg == stt_pkg::PH_LIT_DQ) ? stt_pkg::CH_DQ : stt_pkg::CH_SQ;

        if (end_of_input) begin
            // flush, then end of buffer at the current offset
            a_v = flush_v;
            b_v = 1'b1;
            b_t = stt_pkg::make_tok(stt_pkg::K_EOB, '0, offset_reg, 16'd0,
                                    line_reg, 1'b0);
            restart = 1'b1;
        end else begin
            case (phase_reg)
                stt_pkg::PH_DOT, stt_pkg::PH_LT, stt_pkg::PH_GT,
                stt_pkg::PH_EQ, stt_pkg::PH_BANG: begin
                    if (text_byte == second_ch) begin
                        a_v = 1'b1;
                        a_t = stt_pkg::make_tok(stt_pkg::K_RANGE, '0, start_reg,
                                                16'd2, line_reg, 1'b0);
                        case (phase_reg)
                            stt_pkg::PH_LT:   a_t.token_kind = stt_pkg::K_LE;
                            stt_pkg::PH_GT:   a_t.token_kind = stt_pkg::K_GE;
                            stt_pkg::PH_EQ:   a_t.token_kind = stt_pkg::K_EQEQ;
                            stt_pkg::PH_BANG: a_t.token_kind = stt_pkg::K_NE;
                            default:          a_t.token_kind = stt_pkg::K_RANGE;
                        endcase
                        phase_next = stt_pkg::PH_IDLE;
                    end else begin
                        chain = 1'b1;
                    end
                end
                stt_pkg::PH_IDENT: begin
                    if (is_alpha || is_dig) begin
                        count_next = grow_count;
                        clip_next  = grow_clip;
                    end else begin
                        chain = 1'b1;
                    end
                end
                stt_pkg::PH_NUMBER: begin
                    if (is_dig) begin
                        acc_next   = acc_ovf ? stt_pkg::NUM_MAX : acc_x10[30:0];
                        count_next = grow_count;
                        clip_next  = grow_clip | acc_ovf;
                    end else begin
                        chain = 1'b1;
                    end
                end
                stt_pkg::PH_LIT_SQ, stt_pkg::PH_LIT_DQ: begin
                    if (text_byte == stt_pkg::CH_NUL) begin
                        chain = 1'b1;
                    end else if (text_byte == quote_ch) begin
                        a_v = 1'b1;
                        a_t = stt_pkg::make_tok(stt_pkg::K_LITERAL, '0, start_reg,
                                                count_reg, line_reg, clip_reg);
                        phase_next = stt_pkg::PH_IDLE;
                    end else begin
                        count_next = grow_count;
                        clip_next  = grow_clip;
                    end
                end
                default: chain = 1'b1;
            endcase

            // pending token out, then the byte scanned afresh
            if (chain) begin
                a_v        = flush_v;
                b_v        = fr_emit;
                phase_next = stt_pkg::PH_IDLE;
                if (fr_begin) begin
                    phase_next = fr_phase;
                    start_next = fr_start;
                    count_next = fr_count;
                    acc_next   = fr_acc;
                    clip_next  = 1'b0;
                end
                if (fr_nl) begin
                    line_next = line_reg + 32'd1;
                end
                restart = fr_restart;
            end
        end

        if (restart) begin
            phase_next  = stt_pkg::PH_IDLE;
            acc_next    = '0;
            start_next  = '0;
            count_next  = '0;
            clip_next   = 1'b0;
            line_next   = '0;
            offset_next = '0;
        end
    end

    // pack tokens, first valid one in slot zero
    always_comb begin
        push = '0;
        if (a_v) begin
            push.v0 = 1'b1;
            push.t0 = a_t;
            push.v1 = b_v;
            push.t1 = b_t;
        end else begin
            push.v0 = b_v;
            push.t0 = b_t;
            push.v1 = 1'b0;
            push.t1 = b_t;
        end
        push.t0.last_of_run = ~push.v1;
        push.t1.last_of_run = 1'b1;
        if (!scan_fire) begin
            push.v0 = 1'b0;
            push.v1 = 1'b0;
        end
    end

    // scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= stt_pkg::PH_IDLE;
            acc_reg    <= '0;
            start_reg  <= '0;
            count_reg  <= '0;
            offset_reg <= '0;
            line_reg   <= '0;
            clip_reg   <= 1'b0;
        end else if (scan_fire) begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            start_reg  <= start_next;
            count_reg  <= count_next;
            offset_reg <= offset_next;
            line_reg   <= line_next;
            clip_reg   <= clip_next;
        end
    end

endmodule

### rtl/core/stt_result_queue.sv
// stt_result_queue: shifting result queue that takes up to two tokens a
// cycle and presents the oldest one from a register. Depends on stt_pkg.
`timescale 1ns / 1ps

module stt_result_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  stt_pkg::push_t push,
    output logic           has_room,
    output logic           out_valid,
    input  logic           out_ready,
    output stt_pkg::tok_t  out_tok
);

    stt_pkg::tok_t q_reg [stt_pkg::QDEPTH];
    stt_pkg::tok_t q_next [stt_pkg::QDEPTH];
    logic [stt_pkg::QCNT_BITS-1:0] count_reg, count_next;
    logic [stt_pkg::QCNT_BITS-1:0] base;
    logic                          pop;

    assign out_valid = (count_reg != '0);
    assign out_tok   = q_reg[0];
    assign pop       = out_valid & out_ready;
    assign has_room  = (count_reg <= stt_pkg::QCNT_BITS'(stt_pkg::QDEPTH - 2));
    assign base      = count_reg - stt_pkg::QCNT_BITS'(pop);

    // shift on pop, then write new tokens behind the survivors
    always_comb begin
        for (int i = 0; i < stt_pkg::QDEPTH; i++) begin
            q_next[i] = q_reg[i];
            if (pop && i < stt_pkg::QDEPTH - 1) begin
                q_next[i] = q_reg[(i + 1) % stt_pkg::QDEPTH];
            end
            if (push.v0 && base == stt_pkg::QCNT_BITS'(i)) begin
                q_next[i] = push.t0;
            end
            if (push.v1 && base + 1'b1 == stt_pkg::QCNT_BITS'(i)) begin
                q_next[i] = push.t1;
            end
        end
        count_next = base + stt_pkg::QCNT_BITS'(push.v0)
                          + stt_pkg::QCNT_BITS'(push.v1);
    end

    // occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // entries
    always_ff @(posedge aclk) begin
        for (int i = 0; i < stt_pkg::QDEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

### rtl/core/source_text_tokenizer_core.sv
// source_text_tokenizer_core: top level of the streaming tokenizer.
// Depends on stt_pkg, stt_scanner and stt_result_queue.
`timescale 1ns / 1ps

// Usage
//   Slave channel: one source byte per request in s_tdata[7:0]; s_tlast high
//   marks end of input (the byte is then ignored), which flushes any pending
//   token, sends an end-of-buffer token and restarts offsets and lines at 0.
//   A NUL byte does the same at its own offset.
//   Master channel: one token per request. m_tuser carries kind and the
//   saturation flag, m_tdata the value, offset, length and line; m_tlast is
//   high on the last token caused by one input byte.
//   Path: a byte is held in the input register and scanned into the result
//   queue once the queue has room; its first token is then shown on m_tvalid
//   from the output register of the queue.
//   Throughput: one byte per cycle while m_tready stays high and each byte
//   gives at most one token; a byte that ends a token and starts another of
//   one character gives two, which leave the single read port of the queue in turn.
//   Stalls: a four-entry queue absorbs m_tready low; the scanner waits when
//   fewer than two entries are free and s_tready then drops.
//   Reset (aresetn low, synchronous) empties the queue and clears the scanner.
module source_text_tokenizer_core (
    input  logic          aclk,
    input  logic          aresetn,
    // source bytes
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] text_byte
    input  logic          s_tlast,   // end_of_input
    // tokens
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [111:0]  m_tdata,   // [30:0] number_value, [62:31] start_offset,
                                     // [78:63] token_length, [110:79] line_number,
                                     // [111] zero
    output logic [5:0]    m_tuser,   // [4:0] token_kind, [5] saturated
    output logic          m_tlast    // last_of_run
);

    logic           in_valid_reg;
    logic [7:0]     in_byte_reg;
    logic           in_end_reg;
    logic           has_room;
    logic           scan_fire;
    stt_pkg::push_t push;
    stt_pkg::tok_t  out_tok;

    assign scan_fire = in_valid_reg & has_room;
    assign s_tready  = ~in_valid_reg | scan_fire;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    stt_scanner u_scanner (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .scan_fire    (scan_fire),
        .text_byte    (in_byte_reg),
        .end_of_input (in_end_reg),
        .push         (push)
    );

    stt_result_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .has_room  (has_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (out_tok)
    );

    // output packing
    assign m_tdata = {1'b0, out_tok.line_number, out_tok.token_length,
                      out_tok.start_offset, out_tok.number_value};
    assign m_tuser = {out_tok.saturated, out_tok.token_kind};
    assign m_tlast = out_tok.last_of_run;

    // a second token never comes without a first
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        push.v1 |-> push.v0)
        else $error("second token pushed without first");

    // tokens are never pushed without a scan and queue room
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.v0 || push.v1) |-> (scan_fire && has_room))
        else $error("token pushed without queue room");

    // end of input always closes with an end-of-buffer token
    a_end_eob: assert property (@(posedge aclk) disable iff (!aresetn)
        (scan_fire && in_end_reg) |->
            (push.v0 && ((push.v1 && push.t1.token_kind == stt_pkg::K_EOB) ||
                         (!push.v1 && push.t0.token_kind == stt_pkg::K_EOB))))
        else $error("end of input without end-of-buffer token");

    // only the final token of a pair carries the run mark
    a_last_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.v0 && push.v1) |-> (!push.t0.last_of_run && push.t1.last_of_run))
        else $error("run mark on wrong token");

endmodule
